@@ src/srq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_pkg: shared types and constants of the sorted ready queue
// Entry layout, transfer payloads, operation and status codes.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int DEPTH        = 16;
  localparam int KEY_WIDTH    = 32;
  localparam int HANDLE_WIDTH = 16;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int CNT_W        = $clog2(DEPTH + 1);

  // operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_PEEK   = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // one stored queue entry
  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] handle;
    logic [KEY_WIDTH-1:0]    key;
  } entry_t;

  // input transfer payload
  typedef struct packed {
    logic [1:0]              mode;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [KEY_WIDTH-1:0]    ready_time;
  } in_t;

  // result transfer payload
  typedef struct packed {
    logic [1:0]              status;
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic [KEY_WIDTH-1:0]    out_ready_time;
    logic [CNT_W-1:0]        count;
  } out_t;

endpackage

@@ src/sorted_ready_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_ready_queue: bounded queue of thread handles ordered by ready time
// Append, sorted insert, remove-first and peek on up to DEPTH entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one operation (mode, handle,
//   ready_time). Output channel out_valid_o/out_ready_i returns one result
//   per operation with status, head entry (remove/peek) and the entry count.
//   A single key comparator and one storage read and write port are walked
//   by a small sequencer, one entry per cycle. Sorted insert scans from the
//   head and ripples the later entries back by one slot; append writes the
//   tail slot directly, remove ripples the tail forward, and peek and
//   refused/empty operations go straight to the result. in_ready_o is high
//   only while the sequencer is idle, so one operation is in flight at a time.
//   A finished result sits in the output register; the next operation is
//   accepted while it waits, and that one holds at its last step until the
//   receiver takes the earlier result.
//   Reset empties the queue at once (count zero); no clearing pass.
// ----------------------------------------------------------------------------
module sorted_ready_queue
  import srq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  mode_e                   mode_q, mode_d;
  logic [HANDLE_WIDTH-1:0] hnd_q, hnd_d;
  logic [KEY_WIDTH-1:0]    key_q, key_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    found_q, found_d;
  logic [CNT_W-1:0]        count_q, count_d;
  status_e                 res_st_q, res_st_d;
  logic [HANDLE_WIDTH-1:0] res_hnd_q, res_hnd_d;
  logic [KEY_WIDTH-1:0]    res_key_q, res_key_d;
  logic                    out_valid_q, out_valid_d;
  out_t                    out_data_q, out_data_d;

  logic                    we;
  logic [IDX_W-1:0]        waddr;
  entry_t                  wdata;
  logic [IDX_W-1:0]        raddr;
  entry_t                  rdata;
  logic [IDX_W-1:0]        idx_inc;
  mode_e                   in_mode;

  assign idx_inc = idx_q + IDX_W'(1);
  assign in_mode = mode_e'(in_data_i.mode);

  srq_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // read address: head while idle, next entry for a remove ripple, else the current entry
  always_comb begin
    if (state_q == S_IDLE) begin
      raddr = '0;
    end else if (mode_q == MODE_REMOVE) begin
      raddr = idx_inc;
    end else begin
      raddr = idx_q;
    end
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    hnd_d       = hnd_q;
    key_d       = key_q;
    idx_d       = idx_q;
    found_d     = found_q;
    count_d     = count_q;
    res_st_d    = res_st_q;
    res_hnd_d   = res_hnd_q;
    res_key_d   = res_key_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = '{handle: hnd_q, key: key_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d    = in_mode;
          hnd_d     = in_data_i.handle;
          key_d     = in_data_i.ready_time;
          res_st_d  = ST_DONE;
          res_hnd_d = '0;
          res_key_d = '0;
          unique case (in_mode)
            MODE_APPEND, MODE_INSERT: begin
              if (count_q == CNT_W'(DEPTH)) begin
                res_st_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                // append starts at the tail with the slot already chosen
                idx_d   = (in_mode == MODE_APPEND) ? count_q[IDX_W-1:0] : '0;
                found_d = (in_mode == MODE_APPEND);
                state_d = S_WALK;
              end
            end
            MODE_REMOVE, MODE_PEEK: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                res_hnd_d = rdata.handle;
                res_key_d = rdata.key;
                idx_d     = '0;
                state_d   = (in_mode == MODE_REMOVE) ? S_WALK : S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_WALK: begin
        if (mode_q == MODE_REMOVE) begin
          // shift each later entry forward by one slot
          if (CNT_W'(idx_inc) == count_q || idx_inc == '0) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_DONE;
          end else begin
            we    = 1'b1;
            wdata = rdata;
            idx_d = idx_inc;
          end
        end else if (CNT_W'(idx_q) == count_q) begin
          // tail slot takes the carried entry
          we      = 1'b1;
          count_d = count_q + CNT_W'(1);
          state_d = S_DONE;
        end else if (found_q || (rdata.key > key_q)) begin
          // place carried entry, carry the displaced one onward
          we      = 1'b1;
          hnd_d   = rdata.handle;
          key_d   = rdata.key;
          found_d = 1'b1;
          idx_d   = idx_inc;
        end else begin
          idx_d = idx_inc;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = '{status:         res_st_q,
                          out_handle:     res_hnd_q,
                          out_ready_time: res_key_q,
                          count:          count_q};
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_APPEND;
      hnd_q       <= '0;
      key_q       <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      count_q     <= '0;
      res_st_q    <= ST_DONE;
      res_hnd_q   <= '0;
      res_key_q   <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      hnd_q       <= hnd_d;
      key_q       <= key_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      count_q     <= count_d;
      res_st_q    <= res_st_d;
      res_hnd_q   <= res_hnd_d;
      res_key_q   <= res_key_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // entry count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // a refused append or insert only happens on a full queue
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_FULL) |->
      (out_data_o.count == CNT_W'(DEPTH) && out_data_o.out_handle == '0))
    else $error("full status with room left");

  // an empty result carries no entry and a zero count
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_EMPTY) |->
      (out_data_o.count == '0 && out_data_o.out_ready_time == '0))
    else $error("empty status with stored entries");

  // an accepted operation blocks the input until it finishes
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready while an operation is in flight");

endmodule

@@ src/srq_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_store: entry storage of the sorted ready queue
// Register file of DEPTH entries, one write and one read port per cycle.
// ----------------------------------------------------------------------------
module srq_store
  import srq_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [DEPTH];

  // single write port, contents undefined until written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // single read port
  assign rdata_o = mem_q[raddr_i];

endmodule
